FILE: rtl/ptb_pkg.sv
// ----------------------------------------------------------------------------
// ptb_pkg
// Shared sizes, codes and bundle types of the periodic timer bank.
// ----------------------------------------------------------------------------
package ptb_pkg;

    localparam int SLOTS = 16;
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);

    typedef enum logic [2:0] {
        CMD_TICK       = 3'd0,
        CMD_CREATE     = 3'd1,
        CMD_KILL       = 3'd2,
        CMD_SET_EN     = 3'd3,
        CMD_GET_EN     = 3'd4,
        CMD_RESET      = 3'd5,
        CMD_STOP       = 3'd6,
        CMD_SET_PERIOD = 3'd7
    } t_cmd;

    typedef enum logic [1:0] {
        RK_RESP   = 2'd0,
        RK_EXPIRE = 2'd1,
        RK_DONE   = 2'd2
    } t_rkind;

    typedef enum logic [2:0] {
        WR_NONE   = 3'd0,
        WR_NEW    = 3'd1,
        WR_ENABLE = 3'd2,
        WR_COUNT  = 3'd3,
        WR_STOP   = 3'd4,
        WR_PERIOD = 3'd5,
        WR_SHIFT  = 3'd6
    } t_wop;

    typedef struct packed {
        logic [31:0] id;
        logic        enabled;
        logic [31:0] period;
        logic [31:0] count;
    } t_slot;

    typedef struct packed {
        t_wop             op;
        logic [IDX_W-1:0] idx;
        t_slot            data;
    } t_wr;

    typedef struct packed {
        logic        eq;
        logic        le;
        logic [32:0] diff;
    } t_alu;

    typedef struct packed {
        logic        valid;
        t_rkind      kind;
        logic [31:0] id;
        logic        ok;
        logic        is_en;
        logic [31:0] over;
        logic        last;
    } t_res;

endpackage

FILE: rtl/ptb_store.sv
// ----------------------------------------------------------------------------
// ptb_store
// Slot register file: one scan read port, field writes and kill compaction.
// ----------------------------------------------------------------------------
module ptb_store import ptb_pkg::*; (
    input  logic             i_clk,
    input  t_wr              i_wr,
    input  logic [IDX_W-1:0] i_rd_idx,
    output t_slot            o_rd
);

    t_slot r_mem [SLOTS];

    assign o_rd = r_mem[i_rd_idx];

    always_ff @(posedge i_clk) begin
        unique case (i_wr.op)
            WR_NEW:    r_mem[i_wr.idx] <= i_wr.data;
            WR_ENABLE: r_mem[i_wr.idx].enabled <= i_wr.data.enabled;
            WR_COUNT:  r_mem[i_wr.idx].count <= i_wr.data.count;
            WR_STOP: begin
                r_mem[i_wr.idx].count   <= i_wr.data.count;
                r_mem[i_wr.idx].enabled <= 1'b0;
            end
            WR_PERIOD: r_mem[i_wr.idx].period <= i_wr.data.period;
            WR_SHIFT: begin
                // later slots move down one place, creation order kept
                for (int i = 0; i < SLOTS - 1; i++) begin
                    if (IDX_W'(i) >= i_wr.idx) begin
                        r_mem[i] <= r_mem[i+1];
                    end
                end
            end
            default: ;
        endcase
    end

endmodule

FILE: rtl/ptb_unit.sv
// ----------------------------------------------------------------------------
// ptb_unit
// Shared compare and subtract unit used by every scan of the sequencer.
// ----------------------------------------------------------------------------
module ptb_unit import ptb_pkg::*; (
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output t_alu        o_res
);

    logic [32:0] diff;

    assign diff       = {1'b0, i_a} - {1'b0, i_b};
    assign o_res.diff = diff;
    assign o_res.eq   = (diff == 33'd0);
    assign o_res.le   = diff[32] | (diff == 33'd0);

endmodule

FILE: rtl/ptb_ctrl.sv
// ----------------------------------------------------------------------------
// ptb_ctrl
// Command sequencer: slot scans for lookup, ID choice and tick countdown.
// ----------------------------------------------------------------------------
module ptb_ctrl import ptb_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [2:0]       i_kind,
    input  logic [31:0]      i_timer_id,
    input  logic [31:0]      i_amount,
    input  logic             i_enable,
    input  t_slot            i_rd,
    input  t_alu             i_alu,
    output logic [IDX_W-1:0] o_rd_idx,
    output t_wr              o_wr,
    output logic [31:0]      o_alu_a,
    output logic [31:0]      o_alu_b,
    output t_res             o_res,
    output logic             o_busy
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_FIND   = 7'b0000010,
        S_TICK   = 7'b0000100,
        S_DONE   = 7'b0001000,
        S_CAND   = 7'b0010000,
        S_CHK    = 7'b0100000,
        S_COMMIT = 7'b1000000
    } t_state;

    t_state           r_state,   n_state;
    t_cmd             r_kind,    n_kind;
    logic [31:0]      r_id,      n_id;
    logic [31:0]      r_amount,  n_amount;
    logic             r_enable,  n_enable;
    logic [IDX_W-1:0] r_idx,     n_idx;
    logic [CNT_W-1:0] r_count,   n_count;
    logic [31:0]      r_next_id, n_next_id;
    logic [31:0]      r_cand,    n_cand;
    logic             last_idx;

    assign last_idx = (CNT_W'(r_idx) == r_count - CNT_W'(1));
    assign o_rd_idx = r_idx;
    assign o_busy   = (r_state != S_IDLE);

    always_comb begin
        o_alu_a = i_rd.id;
        o_alu_b = r_id;
        unique case (r_state)
            S_TICK: begin
                o_alu_a = i_rd.count;
                o_alu_b = r_amount;
            end
            S_CHK:   o_alu_b = r_cand;
            default: ;
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_kind    = r_kind;
        n_id      = r_id;
        n_amount  = r_amount;
        n_enable  = r_enable;
        n_idx     = r_idx;
        n_count   = r_count;
        n_next_id = r_next_id;
        n_cand    = r_cand;

        o_wr      = '0;
        o_wr.op   = WR_NONE;
        o_wr.idx  = r_idx;

        o_res       = '0;
        o_res.kind  = RK_RESP;
        o_res.id    = r_id;
        o_res.last  = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_kind   = t_cmd'(i_kind);
                    n_id     = i_timer_id;
                    n_amount = i_amount;
                    n_enable = i_enable;
                    n_idx    = '0;
                    unique case (t_cmd'(i_kind))
                        CMD_TICK: begin
                            n_state = (r_count == '0) ? S_DONE : S_TICK;
                        end
                        CMD_CREATE: begin
                            if (r_count == CNT_W'(SLOTS)) begin
                                // bank full
                                o_res.valid = 1'b1;
                                o_res.id    = 32'd0;
                            end else begin
                                n_cand  = r_next_id + 32'd1;
                                n_state = S_CAND;
                            end
                        end
                        default: begin
                            if (i_timer_id == 32'd0 || r_count == '0) begin
                                o_res.valid = 1'b1;
                                o_res.id    = i_timer_id;
                            end else begin
                                n_state = S_FIND;
                            end
                        end
                    endcase
                end
            end
            S_FIND: begin
                if (i_alu.eq) begin
                    o_res.valid = 1'b1;
                    o_res.ok    = 1'b1;
                    n_state     = S_IDLE;
                    unique case (r_kind)
                        CMD_KILL: begin
                            o_wr.op = WR_SHIFT;
                            n_count = r_count - CNT_W'(1);
                        end
                        CMD_SET_EN: begin
                            o_wr.op           = WR_ENABLE;
                            o_wr.data.enabled = r_enable;
                        end
                        CMD_GET_EN: o_res.is_en = i_rd.enabled;
                        CMD_RESET: begin
                            o_wr.op         = WR_COUNT;
                            o_wr.data.count = i_rd.period;
                        end
                        CMD_STOP: begin
                            o_wr.op         = WR_STOP;
                            o_wr.data.count = i_rd.period;
                        end
                        CMD_SET_PERIOD: begin
                            o_wr.op          = WR_PERIOD;
                            o_wr.data.period = r_amount;
                        end
                        default: ;
                    endcase
                end else if (last_idx) begin
                    o_res.valid = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_TICK: begin
                if (i_rd.enabled) begin
                    o_wr.op = WR_COUNT;
                    if (i_alu.le) begin
                        o_res.valid     = 1'b1;
                        o_res.kind      = RK_EXPIRE;
                        o_res.id        = i_rd.id;
                        o_res.ok        = 1'b1;
                        o_res.over      = 32'd0 - i_alu.diff[31:0];
                        o_res.last      = 1'b0;
                        o_wr.data.count = i_rd.period;
                    end else begin
                        o_wr.data.count = i_alu.diff[31:0];
                    end
                end
                if (last_idx) begin
                    n_state = S_DONE;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_DONE: begin
                o_res.valid = 1'b1;
                o_res.kind  = RK_DONE;
                o_res.id    = 32'd0;
                o_res.ok    = 1'b1;
                n_state     = S_IDLE;
            end
            S_CAND: begin
                // zero is never handed out
                n_cand  = (r_cand == 32'd0) ? 32'd1 : r_cand;
                n_idx   = '0;
                n_state = (r_count == '0) ? S_COMMIT : S_CHK;
            end
            S_CHK: begin
                if (i_alu.eq) begin
                    n_cand  = r_cand + 32'd1;
                    n_state = S_CAND;
                end else if (last_idx) begin
                    n_state = S_COMMIT;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_COMMIT: begin
                o_wr.op           = WR_NEW;
                o_wr.idx          = r_count[IDX_W-1:0];
                o_wr.data.id      = r_cand;
                o_wr.data.enabled = 1'b1;
                o_wr.data.period  = r_amount;
                o_wr.data.count   = r_amount;
                n_count           = r_count + CNT_W'(1);
                n_next_id         = r_cand;
                o_res.valid       = 1'b1;
                o_res.id          = r_cand;
                o_res.ok          = 1'b1;
                n_state           = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_next_id <= 32'd0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_next_id <= n_next_id;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_id     <= n_id;
        r_amount <= n_amount;
        r_enable <= n_enable;
        r_idx    <= n_idx;
        r_cand   <= n_cand;
    end

endmodule

FILE: rtl/periodic_timer_bank.sv
// ----------------------------------------------------------------------------
// periodic_timer_bank
// Bank of periodic countdown timers addressed by ID, kept in creation order.
// ----------------------------------------------------------------------------
// Usage: drive i_kind, i_timer_id, i_amount and i_enable with start high; the
// item is taken at an edge where busy is low. Results come out one per cycle
// on the o_ ports, each marked by o_strobe for exactly one cycle, and the
// final result of an item carries o_last. The receiver cannot stall, so no
// result waits.
// One slot register file is scanned through one shared compare/subtract
// unit, one slot per cycle:
//   tick: every live timer is scanned, then a done step follows
//   kill, set/get enable, reset, stop, set period: scan until the ID matches
//   create: candidate IDs are checked against all live slots until one is free
//   commands other than tick and create with ID zero or on an empty bank,
//   or create on a full bank: answer in the cycle after start, busy stays low
// Expiry results of a tick come out while the scan runs, then tick done.
// Reset (synchronous, active low) empties the bank and restarts IDs at one;
// the slot contents need no clearing.
// ----------------------------------------------------------------------------
module periodic_timer_bank import ptb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_kind,
    input  logic [31:0] i_timer_id,
    input  logic [31:0] i_amount,
    input  logic        i_enable,
    output logic        o_strobe,
    output logic [1:0]  o_result_kind,
    output logic [31:0] o_result_id,
    output logic        o_ok,
    output logic        o_is_enabled,
    output logic [31:0] o_overshoot,
    output logic        o_last
);

    logic [IDX_W-1:0] rd_idx;
    t_slot            rd;
    t_wr              wr;
    logic [31:0]      alu_a;
    logic [31:0]      alu_b;
    t_alu             alu;
    t_res             n_res;
    t_res             r_res;

    ptb_store u_store (
        .i_clk    (i_clk),
        .i_wr     (wr),
        .i_rd_idx (rd_idx),
        .o_rd     (rd)
    );

    ptb_unit u_unit (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .o_res (alu)
    );

    ptb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_kind     (i_kind),
        .i_timer_id (i_timer_id),
        .i_amount   (i_amount),
        .i_enable   (i_enable),
        .i_rd       (rd),
        .i_alu      (alu),
        .o_rd_idx   (rd_idx),
        .o_wr       (wr),
        .o_alu_a    (alu_a),
        .o_alu_b    (alu_b),
        .o_res      (n_res),
        .o_busy     (busy)
    );

    // result register, only the strobe is cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res.valid <= 1'b0;
        end else begin
            r_res <= n_res;
        end
    end

    assign o_strobe      = r_res.valid;
    assign o_result_kind = r_res.kind;
    assign o_result_id   = r_res.id;
    assign o_ok          = r_res.ok;
    assign o_is_enabled  = r_res.is_en;
    assign o_overshoot   = r_res.over;
    assign o_last        = r_res.last;

endmodule

FILE: rtl/ptb_checker.sv
// ----------------------------------------------------------------------------
// ptb_checker
// Port-level checks of the timer bank sequencing, bound to the top level.
// ----------------------------------------------------------------------------
module ptb_checker import ptb_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic [2:0]  i_kind,
    input logic        o_strobe,
    input logic [1:0]  o_result_kind,
    input logic        o_ok,
    input logic        o_last
);

    // a tick always runs at least the done step
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_kind == CMD_TICK) |=> busy)
        else $error("tick item did not make the bank busy");

    // any other item either runs a scan or answers at once
    a_cmd_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_kind != CMD_TICK) |=> (busy || (o_strobe && o_last)))
        else $error("command item neither busy nor answered");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last) |-> !busy)
        else $error("final result shown while still busy");

    a_fell_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $fell(busy)) |-> (o_strobe && o_last))
        else $error("busy dropped without a final result");

    a_expire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result_kind == RK_EXPIRE) |-> (busy && o_ok && !o_last))
        else $error("expiry result outside a running tick");

endmodule

bind periodic_timer_bank ptb_checker u_ptb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .i_kind        (i_kind),
    .o_strobe      (o_strobe),
    .o_result_kind (o_result_kind),
    .o_ok          (o_ok),
    .o_last        (o_last)
);

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the periodic timer bank. A scoreboard class keeps
// a shadow copy of the slot file, predicts the responses, expiries and tick
// done results of each accepted item, and checks the result stream in order.
// ----------------------------------------------------------------------------
module tb_top;
    import ptb_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 200;
    localparam int DRAIN_CYCLES = 2 * (SLOTS + 2);
    localparam int PRINT_CAP    = 30;

    typedef struct {
        t_rkind      kind;
        logic [31:0] id;
        logic        ok;
        logic        is_en;
        logic [31:0] over;
        logic        last;
    } bank_result_t;

    class timer_bank_scoreboard;
        bank_result_t       expected_results[$];
        int                 errors;
        int                 results_seen;
        int                 expiries_seen;
        int                 full_refusals;
        int                 total_items;
        int                 items_by_kind[8];
        // shadow of the slot file
        logic               live[SLOTS];
        logic [31:0]        ids[SLOTS];
        logic               enabled[SLOTS];
        logic [31:0]        period[SLOTS];
        logic signed [32:0] countdown[SLOTS];
        logic [31:0]        next_id;
        logic [31:0]        last_killed;

        function new();
            errors        = 0;
            results_seen  = 0;
            expiries_seen = 0;
            full_refusals = 0;
            total_items   = 0;
            foreach (items_by_kind[k]) items_by_kind[k] = 0;
            foreach (live[i]) live[i] = 1'b0;
            next_id     = '0;
            last_killed = '0;
        endfunction

        task report(string msg);
            errors++;
            if (errors <= PRINT_CAP) $display("ERROR @%0t: %s", $time, msg);
        endtask

        function int find_slot(logic [31:0] id);
            if (id == '0) return -1;
            for (int i = 0; i < SLOTS; i++)
                if (live[i] && ids[i] == id) return i;
            return -1;
        endfunction

        function int live_count();
            int n;
            n = 0;
            for (int i = 0; i < SLOTS; i++)
                if (live[i]) n++;
            return n;
        endfunction

        function void push_result(t_rkind kind, logic [31:0] id, logic ok, logic is_en,
                                  logic [31:0] over, logic last);
            bank_result_t r;
            r.kind  = kind;
            r.id    = id;
            r.ok    = ok;
            r.is_en = is_en;
            r.over  = over;
            r.last  = last;
            expected_results.insert(expected_results.size(), r);
        endfunction

        // advances the shadow state by one item and queues its results
        function void note_command(t_cmd kind, logic [31:0] id, logic [31:0] amount,
                                   logic en);
            int                 s;
            int                 n;
            logic signed [32:0] left;
            logic signed [32:0] past;
            total_items++;
            items_by_kind[kind]++;
            if (kind == CMD_TICK) begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (live[i] && enabled[i]) begin
                        left = countdown[i] - $signed({1'b0, amount});
                        if (left <= 0) begin
                            past = -left;
                            push_result(RK_EXPIRE, ids[i], 1'b1, 1'b0, past[31:0], 1'b0);
                            countdown[i] = $signed({1'b0, period[i]});
                        end else begin
                            countdown[i] = left;
                        end
                    end
                end
                push_result(RK_DONE, '0, 1'b1, 1'b0, '0, 1'b1);
                return;
            end
            if (kind == CMD_CREATE) begin
                n = live_count();
                if (n >= SLOTS) begin
                    full_refusals++;
                    push_result(RK_RESP, '0, 1'b0, 1'b0, '0, 1'b1);
                    return;
                end
                // skip zero and any id still in use after a wrap
                do begin
                    next_id = next_id + 32'd1;
                end while (next_id == '0 || find_slot(next_id) >= 0);
                live[n]      = 1'b1;
                ids[n]       = next_id;
                enabled[n]   = 1'b1;
                period[n]    = amount;
                countdown[n] = $signed({1'b0, amount});
                push_result(RK_RESP, next_id, 1'b1, 1'b0, '0, 1'b1);
                return;
            end
            s = find_slot(id);
            if (s < 0) begin
                push_result(RK_RESP, id, 1'b0, 1'b0, '0, 1'b1);
                return;
            end
            case (kind)
                CMD_KILL: begin
                    // later slots close the gap, creation order kept
                    for (int i = s; i + 1 < SLOTS; i++) begin
                        live[i]      = live[i + 1];
                        ids[i]       = ids[i + 1];
                        enabled[i]   = enabled[i + 1];
                        period[i]    = period[i + 1];
                        countdown[i] = countdown[i + 1];
                    end
                    live[SLOTS - 1] = 1'b0;
                    last_killed     = id;
                end
                CMD_SET_EN: enabled[s] = en;
                CMD_GET_EN: begin
                    push_result(RK_RESP, id, 1'b1, enabled[s], '0, 1'b1);
                    return;
                end
                CMD_RESET: countdown[s] = $signed({1'b0, period[s]});
                CMD_STOP: begin
                    countdown[s] = $signed({1'b0, period[s]});
                    enabled[s]   = 1'b0;
                end
                default: period[s] = amount;
            endcase
            push_result(RK_RESP, id, 1'b1, 1'b0, '0, 1'b1);
        endfunction

        task check_result(bank_result_t got);
            bank_result_t want;
            results_seen++;
            if (expected_results.size() == 0) begin
                report($sformatf("result %0d arrived with nothing expected (kind %0d id %0h)",
                                 results_seen, got.kind, got.id));
                return;
            end
            want = expected_results.pop_front();
            if (want.kind == RK_EXPIRE) expiries_seen++;
            if (got.kind !== want.kind)
                report($sformatf("result %0d: kind %0d, expected %0d",
                                 results_seen, got.kind, want.kind));
            if (got.id !== want.id)
                report($sformatf("result %0d: id %0h, expected %0h",
                                 results_seen, got.id, want.id));
            if (got.ok !== want.ok)
                report($sformatf("result %0d: ok %0b, expected %0b",
                                 results_seen, got.ok, want.ok));
            if (got.is_en !== want.is_en)
                report($sformatf("result %0d: is_enabled %0b, expected %0b",
                                 results_seen, got.is_en, want.is_en));
            if (got.over !== want.over)
                report($sformatf("result %0d: overshoot %0h, expected %0h",
                                 results_seen, got.over, want.over));
            if (got.last !== want.last)
                report($sformatf("result %0d: last %0b, expected %0b",
                                 results_seen, got.last, want.last));
        endtask
    endclass

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        start      = 1'b0;
    logic [2:0]  i_kind     = '0;
    logic [31:0] i_timer_id = '0;
    logic [31:0] i_amount   = '0;
    logic        i_enable   = 1'b0;
    logic        busy;
    logic        o_strobe;
    logic [1:0]  o_result_kind;
    logic [31:0] o_result_id;
    logic        o_ok;
    logic        o_is_enabled;
    logic [31:0] o_overshoot;
    logic        o_last;

    timer_bank_scoreboard sb;

    periodic_timer_bank uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_kind       (i_kind),
        .i_timer_id   (i_timer_id),
        .i_amount     (i_amount),
        .i_enable     (i_enable),
        .o_strobe     (o_strobe),
        .o_result_kind(o_result_kind),
        .o_result_id  (o_result_id),
        .o_ok         (o_ok),
        .o_is_enabled (o_is_enabled),
        .o_overshoot  (o_overshoot),
        .o_last       (o_last)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // holds start high until the item is taken; start stays high on return
    task automatic send_item(t_cmd kind, logic [31:0] id, logic [31:0] amount, logic en);
        start      <= 1'b1;
        i_kind     <= kind;
        i_timer_id <= id;
        i_amount   <= amount;
        i_enable   <= en;
        do @(posedge i_clk); while (busy !== 1'b0);
        sb.note_command(kind, id, amount, en);
    endtask

    task automatic pause_sender(int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic wait_for_results();
        start <= 1'b0;
        do @(posedge i_clk); while (sb.expected_results.size() != 0);
    endtask

    task automatic send_random_item(bit shrinking);
        t_cmd        kind;
        logic [31:0] id;
        logic [31:0] amount;
        int          roll;
        int          create_hi;
        int          kill_hi;
        int          n;
        create_hi = shrinking ? 38 : 50;
        kill_hi   = shrinking ? 60 : 58;
        roll = $urandom_range(0, 99);
        if (roll < 30)             kind = CMD_TICK;
        else if (roll < create_hi) kind = CMD_CREATE;
        else if (roll < kill_hi)   kind = CMD_KILL;
        else                       kind = t_cmd'($urandom_range(CMD_SET_EN, CMD_SET_PERIOD));

        // mostly live ids, with zero, stale and arbitrary ones mixed in
        n    = sb.live_count();
        roll = $urandom_range(0, 99);
        if (kind == CMD_TICK || kind == CMD_CREATE) id = $urandom();
        else if (roll < 75 && n > 0)                id = sb.ids[$urandom_range(0, n - 1)];
        else if (roll < 82)                         id = '0;
        else if (roll < 90)                         id = sb.last_killed;
        else                                        id = $urandom();

        roll = $urandom_range(0, 99);
        if (kind == CMD_TICK) begin
            if (roll < 70)      amount = $urandom_range(0, 20);
            else if (roll < 90) amount = $urandom_range(0, 300);
            else                amount = $urandom();
        end else if (kind == CMD_CREATE || kind == CMD_SET_PERIOD) begin
            if (roll < 10)      amount = '0;
            else if (roll < 75) amount = $urandom_range(1, 40);
            else if (roll < 90) amount = $urandom_range(41, 1000);
            else                amount = $urandom();
        end else begin
            amount = $urandom();
        end
        send_item(kind, id, amount, 1'(($urandom_range(0, 1))));
    endtask

    always @(posedge i_clk) begin : result_monitor
        bank_result_t got;
        if (i_rst_n === 1'b1 && o_strobe === 1'b1) begin
            got.kind  = t_rkind'(o_result_kind);
            got.id    = o_result_id;
            got.ok    = o_ok;
            got.is_en = o_is_enabled;
            got.over  = o_overshoot;
            got.last  = o_last;
            sb.check_result(got);
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((start === 1'b1 && busy === 1'b0) || o_strobe === 1'b1) idle = 0;
            else idle++;
        end
        $display("periodic_timer_bank regression: fail");
        $finish;
    end

    initial begin : stimulus
        int sent;
        int burst;
        sb = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, every command, the corner cases
        send_item(CMD_SET_PERIOD, '0, 32'd7, 1'b0);      // id zero on an empty bank
        send_item(CMD_CREATE, $urandom(), '0, 1'b0);     // period zero
        send_item(CMD_CREATE, $urandom(), '1, 1'b1);     // largest period
        for (int k = 0; k < 13; k++)
            send_item(CMD_CREATE, $urandom(), $urandom_range(1, 12), 1'($urandom_range(0, 1)));
        send_item(CMD_TICK, $urandom(), '0, 1'b0);       // zero elapsed fires period zero
        send_item(CMD_CREATE, $urandom(), 32'd3, 1'b0);  // bank now full
        send_item(CMD_CREATE, $urandom(), 32'd9, 1'b0);  // refused
        send_item(CMD_TICK, $urandom(), '1, 1'b1);       // largest elapsed fires all
        send_item(CMD_SET_EN, 32'd1, $urandom(), 1'b0);
        send_item(CMD_GET_EN, 32'd1, $urandom(), 1'b1);
        send_item(CMD_STOP, 32'd3, $urandom(), 1'b1);
        send_item(CMD_SET_PERIOD, 32'd3, 32'd4, 1'b0);
        send_item(CMD_RESET, 32'd4, $urandom(), 1'b0);
        send_item(CMD_KILL, 32'd2, $urandom(), 1'b0);
        send_item(CMD_KILL, 32'd2, $urandom(), 1'b1);    // already gone
        wait_for_results();

        // random bursts, alternating between growing and shrinking the bank
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 16);
            for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
                send_random_item(1'((sent / 50) % 2));
                sent++;
                if (sent == RANDOM_ITEMS / 2) wait_for_results();
            end
            if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 8));
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.expected_results.size() != 0)
            sb.report($sformatf("%0d expected results never arrived",
                                sb.expected_results.size()));

        $display("ran %0d items: %0d ticks, %0d creates (%0d refused on a full bank)",
                 sb.total_items, sb.items_by_kind[CMD_TICK], sb.items_by_kind[CMD_CREATE],
                 sb.full_refusals);
        $display("checked %0d results including %0d expiries, %0d mismatches",
                 sb.results_seen, sb.expiries_seen, sb.errors);
        if (sb.errors == 0) begin
            $display("periodic_timer_bank regression: pass");
        end else begin
            $display("periodic_timer_bank regression: fail");
        end
        $finish;
    end

endmodule
